// File: hw/rtl/lja_pkg.sv
// ----------------------------------------------------------------------------
// lja_pkg
// Shared types, constants and helpers for the leg joint angle to servo
// command core.
// ----------------------------------------------------------------------------
package lja_pkg;

    localparam int NUM_LANES = 3;

    localparam int LANE_COXA  = 0;
    localparam int LANE_FEMUR = 1;
    localparam int LANE_TIBIA = 2;

    // Angles after the quarter-pi offset and optional negation
    localparam int ANGLE_W = 17;
    localparam int TRIM_W  = 10;
    localparam int POS_W   = 16;
    localparam int SPEED_W = 8;
    localparam int CFG_W   = 16;
    localparam int LEG_W   = 3;

    // Q.12 angle times Q10.6 scale gives Q.18
    localparam int PROD_W     = 2 * ANGLE_W;
    localparam int FRAC_BITS  = 18;
    localparam int RMAG_W     = 14;
    localparam int SUM_W      = 19;
    localparam int REM_W      = 17;

    localparam logic signed [ANGLE_W-1:0] QUARTER_PI_Q12 = 17'sd3217;

    localparam int NEUTRAL_POSITION_DEF = 1500;
    localparam int REFRESH_RATE_DEF     = 50;

    localparam logic [LEG_W-1:0]  LEG_NUMBER_RST       = 3'd0;
    localparam logic [TRIM_W-1:0] TRIM_RST             = 10'd0;
    localparam logic [CFG_W-1:0]  SCALE_PER_RADIAN_RST = 16'd40743;
    localparam logic [CFG_W-1:0]  POSITION_FLOOR_RST   = 16'd500;
    localparam logic [CFG_W-1:0]  POSITION_CEIL_RST    = 16'd2500;
    localparam logic [CFG_W-1:0]  TRAVEL_TIME_RST      = 16'd0;

    typedef enum logic [2:0] {
        CFG_LEG_NUMBER       = 3'd0,
        CFG_COXA_TRIM        = 3'd1,
        CFG_FEMUR_TRIM       = 3'd2,
        CFG_TIBIA_TRIM       = 3'd3,
        CFG_SCALE_PER_RADIAN = 3'd4,
        CFG_POSITION_FLOOR   = 3'd5,
        CFG_POSITION_CEILING = 3'd6,
        CFG_TRAVEL_TIME      = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_POS,
        ST_DIV_INIT,
        ST_DIV,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic pos;
        logic div_init;
        logic div_step;
    } lane_ctrl_t;

    typedef struct packed {
        logic signed [15:0] coxa_angle;
        logic signed [15:0] femur_angle;
        logic signed [15:0] tibia_angle;
    } angle_item_t;

    typedef struct packed {
        logic [POS_W-1:0]   coxa_position;
        logic [POS_W-1:0]   femur_position;
        logic [POS_W-1:0]   tibia_position;
        logic [SPEED_W-1:0] coxa_speed;
        logic [SPEED_W-1:0] femur_speed;
        logic [SPEED_W-1:0] tibia_speed;
    } command_t;

    // Dividend width of the speed divide: 2*d*rate + travel_time
    function automatic int num_width(input int rate);
        return 16 + $clog2(2 * rate + 2);
    endfunction

endpackage

// File: hw/rtl/leg_joint_angle_to_servo_command_core.sv
// ----------------------------------------------------------------------------
// leg_joint_angle_to_servo_command_core
// Three joint angles in, three clamped servo positions and speeds out.
//
//   channel   direction  handshake                     payload
//   angle     in         angle_valid / angle_stall     angle_item_t
//   command   out        command_valid / command_stall command_t
//   cfg       in         cfg_we, cfg_index             cfg_data (16 bit)
//
// One item at a time. Accept, multiply, clamp, divide setup, then one
// cycle per quotient bit of the speed divide (16 + clog2(2*REFRESH_RATE+2)
// bits, 23 at the default rate); the result is then loaded into the output
// register once it is free, and only after that is the next item taken.
// All three joints run in their own lane at once. A stalled command holds
// the sequencer in its last state. Reset restores register defaults and
// neutral last positions.
// ----------------------------------------------------------------------------
module leg_joint_angle_to_servo_command_core
    import lja_pkg::*;
#(
    parameter int NEUTRAL_POSITION = NEUTRAL_POSITION_DEF,
    parameter int REFRESH_RATE     = REFRESH_RATE_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              angle_valid,
    output logic              angle_stall,
    input  angle_item_t       angle_data,
    output logic              command_valid,
    input  logic              command_stall,
    output command_t          command_data,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    logic [LEG_W-1:0]  leg_number_reg;
    logic [TRIM_W-1:0] coxa_trim_reg;
    logic [TRIM_W-1:0] femur_trim_reg;
    logic [TRIM_W-1:0] tibia_trim_reg;
    logic [CFG_W-1:0]  scale_reg;
    logic [CFG_W-1:0]  floor_reg;
    logic [CFG_W-1:0]  ceil_reg;
    logic [CFG_W-1:0]  travel_time_reg;

    logic signed [ANGLE_W-1:0] lane_angle [NUM_LANES];
    logic signed [TRIM_W-1:0]  lane_trim [NUM_LANES];
    logic [POS_W-1:0]          lane_pos [NUM_LANES];
    logic [SPEED_W-1:0]        lane_speed [NUM_LANES];
    logic signed [ANGLE_W-1:0] femur_off;
    logic signed [ANGLE_W-1:0] tibia_off;

    lane_ctrl_t lane_ctrl;
    logic       merge_free;
    logic       merge_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leg_number_reg  <= LEG_NUMBER_RST;
            coxa_trim_reg   <= TRIM_RST;
            femur_trim_reg  <= TRIM_RST;
            tibia_trim_reg  <= TRIM_RST;
            scale_reg       <= SCALE_PER_RADIAN_RST;
            floor_reg       <= POSITION_FLOOR_RST;
            ceil_reg        <= POSITION_CEIL_RST;
            travel_time_reg <= TRAVEL_TIME_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LEG_NUMBER:       leg_number_reg  <= cfg_data[LEG_W-1:0];
                CFG_COXA_TRIM:        coxa_trim_reg   <= cfg_data[TRIM_W-1:0];
                CFG_FEMUR_TRIM:       femur_trim_reg  <= cfg_data[TRIM_W-1:0];
                CFG_TIBIA_TRIM:       tibia_trim_reg  <= cfg_data[TRIM_W-1:0];
                CFG_SCALE_PER_RADIAN: scale_reg       <= cfg_data;
                CFG_POSITION_FLOOR:   floor_reg       <= cfg_data;
                CFG_POSITION_CEILING: ceil_reg        <= cfg_data;
                CFG_TRAVEL_TIME:      travel_time_reg <= cfg_data;
                default:              leg_number_reg  <= leg_number_reg;
            endcase
        end
    end

    // femur and tibia are referenced to pi/4 and mirrored on odd legs
    always_comb
    begin
        femur_off = ANGLE_W'(angle_data.femur_angle) - QUARTER_PI_Q12;
        tibia_off = ANGLE_W'(angle_data.tibia_angle) - QUARTER_PI_Q12;
        lane_angle[LANE_COXA]  = ANGLE_W'(angle_data.coxa_angle);
        lane_angle[LANE_FEMUR] = leg_number_reg[0] ? -femur_off : femur_off;
        lane_angle[LANE_TIBIA] = leg_number_reg[0] ? -tibia_off : tibia_off;
        lane_trim[LANE_COXA]   = $signed(coxa_trim_reg);
        lane_trim[LANE_FEMUR]  = $signed(femur_trim_reg);
        lane_trim[LANE_TIBIA]  = $signed(tibia_trim_reg);
    end

    lja_ctrl #(
        .REFRESH_RATE (REFRESH_RATE)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .angle_valid (angle_valid),
        .merge_free  (merge_free),
        .angle_stall (angle_stall),
        .lane_ctrl   (lane_ctrl),
        .merge_load  (merge_load)
    );

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        lja_lane #(
            .NEUTRAL_POSITION (NEUTRAL_POSITION),
            .REFRESH_RATE     (REFRESH_RATE)
        ) u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (lane_ctrl),
            .angle       (lane_angle[i]),
            .trim        (lane_trim[i]),
            .scale       (scale_reg),
            .pos_floor   (floor_reg),
            .pos_ceil    (ceil_reg),
            .travel_time (travel_time_reg),
            .position    (lane_pos[i]),
            .speed       (lane_speed[i])
        );
    end

    lja_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (merge_load),
        .lane_pos      (lane_pos),
        .lane_speed    (lane_speed),
        .free          (merge_free),
        .command_valid (command_valid),
        .command_stall (command_stall),
        .command_data  (command_data)
    );

endmodule

// File: hw/rtl/lja_lane.sv
// ----------------------------------------------------------------------------
// lja_lane
// One joint: scale, round, offset and clamp the angle, then a bit-serial
// divide for the speed value. Keeps the joint's previous position.
// ----------------------------------------------------------------------------
module lja_lane
    import lja_pkg::*;
#(
    parameter int NEUTRAL_POSITION = NEUTRAL_POSITION_DEF,
    parameter int REFRESH_RATE     = REFRESH_RATE_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  lane_ctrl_t                ctrl,
    input  logic signed [ANGLE_W-1:0] angle,
    input  logic signed [TRIM_W-1:0]  trim,
    input  logic [CFG_W-1:0]          scale,
    input  logic [CFG_W-1:0]          pos_floor,
    input  logic [CFG_W-1:0]          pos_ceil,
    input  logic [CFG_W-1:0]          travel_time,
    output logic [POS_W-1:0]          position,
    output logic [SPEED_W-1:0]        speed
);

    localparam int NUM_W = num_width(REFRESH_RATE);

    logic signed [ANGLE_W-1:0] angle_reg, angle_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [POS_W-1:0]          last_reg, last_next;
    logic [POS_W-1:0]          diff_reg, diff_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [NUM_W-1:0]          quot_reg, quot_next;

    logic [PROD_W-1:0]         mag;
    logic [PROD_W-1:0]         rnd;
    logic [RMAG_W-1:0]         r_mag;
    logic signed [SUM_W-1:0]   r_s;
    logic signed [SUM_W-1:0]   neutral_s;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   ceil_s;
    logic signed [SUM_W-1:0]   floor_s;
    logic signed [SUM_W-1:0]   hi_clamp;
    logic signed [SUM_W-1:0]   lo_clamp;
    logic [POS_W-1:0]          clamp_pos;
    logic [REM_W:0]            shifted;
    logic [REM_W:0]            den;
    logic                      q_bit;

    // rounding half away from zero on the Q.18 product
    always_comb
    begin
        mag       = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        rnd       = mag + (PROD_W'(1) << (FRAC_BITS - 1));
        r_mag     = rnd[FRAC_BITS+RMAG_W-1:FRAC_BITS];
        r_s       = prod_reg[PROD_W-1] ? -$signed(SUM_W'(r_mag)) : $signed(SUM_W'(r_mag));
        neutral_s = SUM_W'(NEUTRAL_POSITION);
        sum       = r_s + neutral_s + SUM_W'(trim);
        ceil_s    = $signed(SUM_W'(pos_ceil));
        floor_s   = $signed(SUM_W'(pos_floor));
        hi_clamp  = (sum > ceil_s) ? ceil_s : sum;
        lo_clamp  = (hi_clamp < floor_s) ? floor_s : hi_clamp;
        clamp_pos = lo_clamp[POS_W-1:0];
    end

    // restoring divide step, one quotient bit per cycle
    always_comb
    begin
        shifted = {rem_reg, quot_reg[NUM_W-1]};
        den     = {1'b0, travel_time, 1'b0};
        q_bit   = (shifted >= den);
    end

    always_comb
    begin
        angle_next = angle_reg;
        prod_next  = prod_reg;
        pos_next   = pos_reg;
        last_next  = last_reg;
        diff_next  = diff_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        if (ctrl.load)
        begin
            angle_next = angle;
        end
        if (ctrl.mul)
        begin
            prod_next = angle_reg * $signed({1'b0, scale});
        end
        if (ctrl.pos)
        begin
            pos_next  = clamp_pos;
            last_next = clamp_pos;
            diff_next = (clamp_pos > last_reg) ? (clamp_pos - last_reg)
                                               : (last_reg - clamp_pos);
        end
        if (ctrl.div_init)
        begin
            rem_next  = '0;
            quot_next = NUM_W'(diff_reg) * NUM_W'(2 * REFRESH_RATE) + NUM_W'(travel_time);
        end
        if (ctrl.div_step)
        begin
            rem_next  = q_bit ? REM_W'(shifted - den) : shifted[REM_W-1:0];
            quot_next = {quot_reg[NUM_W-2:0], q_bit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= POS_W'(NEUTRAL_POSITION);
        end
        else
        begin
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
        prod_reg  <= prod_next;
        pos_reg   <= pos_next;
        diff_reg  <= diff_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
    end

    always_comb
    begin
        priority if (travel_time == '0)
        begin
            speed = '0;
        end
        else if (quot_reg == '0)
        begin
            speed = SPEED_W'(1);
        end
        else if (quot_reg > NUM_W'(255))
        begin
            speed = SPEED_W'(255);
        end
        else
        begin
            speed = quot_reg[SPEED_W-1:0];
        end
    end

    assign position = pos_reg;

endmodule

// File: hw/rtl/lja_ctrl.sv
// ----------------------------------------------------------------------------
// lja_ctrl
// Sequencer shared by all lanes: multiply, clamp, then the serial divide.
// ----------------------------------------------------------------------------
module lja_ctrl
    import lja_pkg::*;
#(
    parameter int REFRESH_RATE = REFRESH_RATE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       angle_valid,
    input  logic       merge_free,
    output logic       angle_stall,
    output lane_ctrl_t lane_ctrl,
    output logic       merge_load
);

    localparam int NUM_W = num_width(REFRESH_RATE);
    localparam int CNT_W = $clog2(NUM_W);

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (angle_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_POS;
            end
            ST_POS:
            begin
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (merge_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        angle_stall = 1'b1;
        lane_ctrl   = '0;
        merge_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                angle_stall    = 1'b0;
                lane_ctrl.load = angle_valid;
            end
            ST_MUL:
            begin
                lane_ctrl.mul = 1'b1;
            end
            ST_POS:
            begin
                lane_ctrl.pos = 1'b1;
            end
            ST_DIV_INIT:
            begin
                lane_ctrl.div_init = 1'b1;
            end
            ST_DIV:
            begin
                lane_ctrl.div_step = 1'b1;
            end
            ST_DONE:
            begin
                merge_load = merge_free;
            end
            default:
            begin
                angle_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: hw/rtl/lja_merge.sv
// ----------------------------------------------------------------------------
// lja_merge
// Gathers the lane results into one command and holds it until transfer.
// ----------------------------------------------------------------------------
module lja_merge
    import lja_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [POS_W-1:0]   lane_pos [NUM_LANES],
    input  logic [SPEED_W-1:0] lane_speed [NUM_LANES],
    output logic               free,
    output logic               command_valid,
    input  logic               command_stall,
    output command_t           command_data
);

    logic     valid_reg, valid_next;
    command_t data_reg, data_next;

    // register can take a new command when empty or draining this cycle
    assign free = !valid_reg || !command_stall;

    always_comb
    begin
        valid_next = valid_reg && command_stall;
        data_next  = data_reg;
        if (load)
        begin
            valid_next                = 1'b1;
            data_next.coxa_position   = lane_pos[LANE_COXA];
            data_next.femur_position  = lane_pos[LANE_FEMUR];
            data_next.tibia_position  = lane_pos[LANE_TIBIA];
            data_next.coxa_speed      = lane_speed[LANE_COXA];
            data_next.femur_speed     = lane_speed[LANE_FEMUR];
            data_next.tibia_speed     = lane_speed[LANE_TIBIA];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign command_valid = valid_reg;
    assign command_data  = data_reg;

endmodule
